// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define MPD_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MPD_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define MPD_ASSERT(label, clk, rst_n, prop, msg)
`define MPD_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif

`endif

// File: src/mpd_pkg.sv
// ----------------------------------------------------------------------------
// MQTT PUBLISH deframer package
// Result kind codes, protocol constants and the result record.
// ----------------------------------------------------------------------------
package mpd_pkg;

    localparam logic [1:0] KIND_TOPIC   = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_END     = 2'd2;

    localparam logic [7:0] HEADER_BYTE  = 8'h30;
    localparam int         TOPIC_W      = 16;

    typedef struct packed {
        logic [7:0] data_byte;
        logic [1:0] byte_kind;
        logic       packet_end;
    } result_t;

endpackage

// File: src/mpd_in_stage.sv
// ----------------------------------------------------------------------------
// Input register
// Holds one received byte until the parser stage takes it.
// ----------------------------------------------------------------------------
module mpd_in_stage
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    input  logic       advance,
    output logic       s1_valid,
    output logic [7:0] s1_byte
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       take;

    assign in_stall   = valid_reg && !advance;
    assign take       = in_valid && !in_stall;
    assign valid_next = take || (valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            byte_reg <= rx_byte;
        end
    end

    assign s1_valid = valid_reg;
    assign s1_byte  = byte_reg;

endmodule

// File: src/mpd_core.sv
// ----------------------------------------------------------------------------
// Parser core
// Packet state and the single-pass state update for one byte.
// ----------------------------------------------------------------------------
module mpd_core
#(
    parameter int MAX_LENGTH_BYTES = 3
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s1_valid,
    input  logic [7:0]      s1_byte,
    input  logic            out_free,
    output logic            advance,
    output logic            res_valid,
    output mpd_pkg::result_t res
);

    localparam int BL_W  = 7 * MAX_LENGTH_BYTES;
    localparam int CMP_W = (BL_W > mpd_pkg::TOPIC_W) ? BL_W : mpd_pkg::TOPIC_W;
    localparam int TW    = mpd_pkg::TOPIC_W;

    localparam logic [2:0] PH_HUNT    = 3'd0;
    localparam logic [2:0] PH_LEN     = 3'd1;
    localparam logic [2:0] PH_TLEN_HI = 3'd2;
    localparam logic [2:0] PH_TLEN_LO = 3'd3;
    localparam logic [2:0] PH_TOPIC   = 3'd4;
    localparam logic [2:0] PH_PAYLOAD = 3'd5;

    logic [2:0]    phase_reg;
    logic [2:0]    phase_next;
    logic [BL_W-1:0] bytes_left_reg;
    logic [BL_W-1:0] bytes_left_next;
    logic [1:0]    length_group_reg;
    logic [1:0]    length_group_next;
    logic [TW-1:0] topic_left_reg;
    logic [TW-1:0] topic_left_next;

    logic [BL_W-1:0] bl_sum;
    logic [BL_W-1:0] bl_dec;
    logic [TW-1:0]   tl_dec;
    logic [TW-1:0]   tl_full;
    logic            last_group;
    logic            at_end;

    assign bl_sum     = bytes_left_reg
                      + (BL_W'(s1_byte[6:0]) << (5'(length_group_reg) * 5'd7));
    assign bl_dec     = bytes_left_reg - BL_W'(1);
    assign tl_dec     = (topic_left_reg != '0) ? topic_left_reg - TW'(1) : '0;
    assign tl_full    = {topic_left_reg[TW-1:8], s1_byte};
    assign last_group = !s1_byte[7]
                     || ((3'(length_group_reg) + 3'd1) >= 3'(MAX_LENGTH_BYTES));
    assign at_end     = (bytes_left_reg <= BL_W'(1));

    always_comb
    begin
        phase_next        = phase_reg;
        bytes_left_next   = bytes_left_reg;
        length_group_next = length_group_reg;
        topic_left_next   = topic_left_reg;
        res_valid         = 1'b0;
        res.data_byte     = s1_byte;
        res.byte_kind     = mpd_pkg::KIND_END;
        res.packet_end    = 1'b1;
        unique case (phase_reg)
            PH_HUNT:
            begin
                if (s1_byte == mpd_pkg::HEADER_BYTE)
                begin
                    phase_next        = PH_LEN;
                    bytes_left_next   = '0;
                    length_group_next = '0;
                    topic_left_next   = '0;
                end
            end
            PH_LEN:
            begin
                bytes_left_next = bl_sum;
                if (last_group)
                begin
                    length_group_next = '0;
                    if (bl_sum == '0)
                    begin
                        phase_next      = PH_HUNT;
                        topic_left_next = '0;
                        res_valid       = 1'b1;
                        res.data_byte   = '0;
                    end
                    else
                    begin
                        phase_next = PH_TLEN_HI;
                    end
                end
                else
                begin
                    length_group_next = length_group_reg + 2'd1;
                end
            end
            PH_TLEN_HI:
            begin
                topic_left_next = {s1_byte, 8'h00};
                bytes_left_next = bl_dec;
                if (bl_dec == '0)
                begin
                    phase_next      = PH_HUNT;
                    topic_left_next = '0;
                    res_valid       = 1'b1;
                    res.data_byte   = '0;
                end
                else
                begin
                    phase_next = PH_TLEN_LO;
                end
            end
            PH_TLEN_LO:
            begin
                bytes_left_next = bl_dec;
                if (bl_dec == '0)
                begin
                    phase_next      = PH_HUNT;
                    topic_left_next = '0;
                    res_valid       = 1'b1;
                    res.data_byte   = '0;
                end
                else
                begin
                    if (CMP_W'(tl_full) > CMP_W'(bl_dec))
                    begin
                        topic_left_next = TW'(bl_dec);
                    end
                    else
                    begin
                        topic_left_next = tl_full;
                    end
                    phase_next = (tl_full != '0) ? PH_TOPIC : PH_PAYLOAD;
                end
            end
            PH_TOPIC:
            begin
                res_valid       = 1'b1;
                res.byte_kind   = mpd_pkg::KIND_TOPIC;
                res.packet_end  = at_end;
                bytes_left_next = at_end ? '0 : bl_dec;
                topic_left_next = tl_dec;
                if (at_end)
                begin
                    phase_next      = PH_HUNT;
                    topic_left_next = '0;
                end
                else if (tl_dec == '0)
                begin
                    phase_next = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD:
            begin
                res_valid       = 1'b1;
                res.byte_kind   = mpd_pkg::KIND_PAYLOAD;
                res.packet_end  = at_end;
                bytes_left_next = at_end ? '0 : bl_dec;
                if (at_end)
                begin
                    phase_next = PH_HUNT;
                end
            end
            default:
            begin
                phase_next        = PH_HUNT;
                bytes_left_next   = '0;
                length_group_next = '0;
                topic_left_next   = '0;
            end
        endcase
    end

    // advance unless a result must wait for the output register
    assign advance = s1_valid && (!res_valid || out_free);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_HUNT;
            bytes_left_reg   <= '0;
            length_group_reg <= '0;
            topic_left_reg   <= '0;
        end
        else if (advance)
        begin
            phase_reg        <= phase_next;
            bytes_left_reg   <= bytes_left_next;
            length_group_reg <= length_group_next;
            topic_left_reg   <= topic_left_next;
        end
    end

endmodule

// File: src/mpd_out_reg.sv
// ----------------------------------------------------------------------------
// Result register
// Holds one result request until the downstream side takes it.
// ----------------------------------------------------------------------------
module mpd_out_reg
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  mpd_pkg::result_t res,
    output logic             out_free,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [7:0]       data_byte,
    output logic [1:0]       byte_kind,
    output logic             packet_end
);

    logic             valid_reg;
    logic             valid_next;
    mpd_pkg::result_t res_reg;

    assign out_free   = !valid_reg || !out_stall;
    assign valid_next = load || (valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign out_valid  = valid_reg;
    assign data_byte  = res_reg.data_byte;
    assign byte_kind  = res_reg.byte_kind;
    assign packet_end = res_reg.packet_end;

endmodule

// File: src/mqtt_publish_deframer_top.sv
// ----------------------------------------------------------------------------
// A byte is held in the input register, its result in the result register.
// Throughput: one byte per cycle via the single parser stage, unless stalled.
// Reset: rst_n clears the parser to hunting for a header byte and
// empties the input and result registers.
// ----------------------------------------------------------------------------
// MQTT PUBLISH deframer top level
// Extracts tagged topic and payload bytes and end markers from a byte stream.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mqtt_publish_deframer_top
#(
    parameter int MAX_LENGTH_BYTES = 3
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] data_byte,
    output logic [1:0] byte_kind,
    output logic       packet_end
);

    logic             s1_valid;
    logic [7:0]       s1_byte;
    logic             advance;
    logic             out_free;
    logic             res_valid;
    mpd_pkg::result_t res;
    logic             out_is_end;
    logic             marker_ok;
    logic             kind_known;
    logic             result_held;

    mpd_in_stage u_in
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .rx_byte  (rx_byte),
        .advance  (advance),
        .s1_valid (s1_valid),
        .s1_byte  (s1_byte)
    );

    mpd_core
    #(
        .MAX_LENGTH_BYTES (MAX_LENGTH_BYTES)
    )
    u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s1_valid  (s1_valid),
        .s1_byte   (s1_byte),
        .out_free  (out_free),
        .advance   (advance),
        .res_valid (res_valid),
        .res       (res)
    );

    mpd_out_reg u_out
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (advance && res_valid),
        .res        (res),
        .out_free   (out_free),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .data_byte  (data_byte),
        .byte_kind  (byte_kind),
        .packet_end (packet_end)
    );

    assign out_is_end  = out_valid && (byte_kind == mpd_pkg::KIND_END);
    assign marker_ok   = packet_end && (data_byte == 8'h00);
    assign kind_known  = (byte_kind == mpd_pkg::KIND_TOPIC)
                      || (byte_kind == mpd_pkg::KIND_PAYLOAD)
                      || (byte_kind == mpd_pkg::KIND_END);
    assign result_held = s1_valid && out_valid && out_stall && res_valid;

    `MPD_ASSERT(a_end_marker_form, clk, rst_n, out_is_end |-> marker_ok, "malformed end marker")
    `MPD_ASSERT_NEVER(a_kind_code, clk, rst_n, out_valid && !kind_known, "undefined byte kind")
    `MPD_ASSERT(a_stall_held, clk, rst_n, in_stall |-> result_held, "stall with no blocked result")

endmodule
